FILE: hdl/zlj_pkg.sv
package zlj_pkg;

  // Line length limit in counted bytes, and the paren depth ceiling.
  localparam int MAX_LINE  = 65536;
  localparam int MAX_DEPTH = 255;

  // Width of the line_length result field.
  localparam int LEN_W = 17;

  // Counter width: must hold MAX_LINE itself, and at least the result field.
  localparam int LINE_CNT_W = $clog2(MAX_LINE + 1);
  localparam int CNT_W      = (LINE_CNT_W > LEN_W) ? LINE_CNT_W : LEN_W;
  localparam int DEPTH_W    = $clog2(MAX_DEPTH + 1);

  // Queue between the front and the back; a power of two.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Characters with a meaning of their own.
  localparam logic [7:0] CH_OPEN   = 8'h28;
  localparam logic [7:0] CH_CLOSE  = 8'h29;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  // Byte class found by the front.
  typedef enum logic [2:0] {
    CLS_OTHER  = 3'd0,
    CLS_QUOTE  = 3'd1,
    CLS_OPEN   = 3'd2,
    CLS_CLOSE  = 3'd3,
    CLS_SEMI   = 3'd4,
    CLS_NL     = 3'd5,
    CLS_BSLASH = 3'd6,
    CLS_EOF    = 3'd7
  } cls_t;

  // Line close status codes.
  typedef enum logic [1:0] {
    STAT_OK            = 2'd0,
    STAT_MISSING_CLOSE = 2'd1,
    STAT_MISSING_OPEN  = 2'd2,
    STAT_NO_LINE       = 2'd3
  } status_t;

  // One queued item: its class and raw byte.
  typedef struct packed {
    cls_t       cls;
    logic [7:0] data;
  } entry_t;

  // Queue status as seen by the back.
  typedef struct packed {
    logic   not_empty;
    entry_t head;
  } fifo_head_t;

endpackage

FILE: hdl/zone_line_joiner.sv
// Channel   Direction  Handshake              Payload
// input     in         in_valid / in_stall    char_byte, end_of_file
// result    out        out_valid / out_stall  char_valid, out_char, line_done,
//                                             line_status, line_length
// config    in         cfg_valid / cfg_ready  cfg_data (hold_comments)
//
// One byte is taken per cycle while the queue has room; each result passes
// through the queue, then the state update into the output register.
// The back part's per-byte state update runs one item a cycle unless stalled.
// Reset is synchronous and clears the line state, queue and hold_comments.
// A stall on the output stops the back part; the input stalls only once the
// four-entry queue is full.
module zone_line_joiner (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  char_byte,
  input  logic        end_of_file,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        char_valid,
  output logic [7:0]  out_char,
  output logic        line_done,
  output logic [1:0]  line_status,
  output logic [16:0] line_length,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);
  import zlj_pkg::*;

  logic       push;
  entry_t     push_entry;
  logic       fifo_full;
  logic       pop;
  fifo_head_t head;

  // The configuration register takes a write in any cycle.
  assign cfg_ready = 1'b1;

  // Front: accept and classify bytes.
  zlj_front u_front (
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .char_byte   (char_byte),
    .end_of_file (end_of_file),
    .fifo_full   (fifo_full),
    .push        (push),
    .push_entry  (push_entry)
  );

  // Queue between the two parts.
  zlj_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (fifo_full),
    .pop        (pop),
    .head       (head)
  );

  // Back: line state and result register.
  zlj_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_data    (cfg_data),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .char_valid  (char_valid),
    .out_char    (out_char),
    .line_done   (line_done),
    .line_status (line_status),
    .line_length (line_length)
  );

endmodule

FILE: hdl/zlj_front.sv
module zlj_front (
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      char_byte,
  input  logic            end_of_file,
  input  logic            fifo_full,
  output logic            push,
  output zlj_pkg::entry_t push_entry
);
  import zlj_pkg::*;

  cls_t cls;

  // Classify the raw byte; end of file overrides the byte.
  always_comb begin
    if (end_of_file) begin
      cls = CLS_EOF;
    end else begin
      case (char_byte)
        CH_QUOTE:  cls = CLS_QUOTE;
        CH_OPEN:   cls = CLS_OPEN;
        CH_CLOSE:  cls = CLS_CLOSE;
        CH_SEMI:   cls = CLS_SEMI;
        CH_NL:     cls = CLS_NL;
        CH_BSLASH: cls = CLS_BSLASH;
        default:   cls = CLS_OTHER;
      endcase
    end
  end

  // A transaction is taken whenever the queue has room.
  assign in_stall        = fifo_full;
  assign push            = in_valid && !fifo_full;
  assign push_entry.cls  = cls;
  assign push_entry.data = char_byte;

endmodule

FILE: hdl/zlj_fifo.sv
module zlj_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  zlj_pkg::entry_t     push_entry,
  output logic                full,
  input  logic                pop,
  output zlj_pkg::fifo_head_t head
);
  import zlj_pkg::*;

  entry_t                mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_CNT_W-1:0] count;

  assign full           = (count == FIFO_CNT_W'(FIFO_DEPTH));
  assign head.not_empty = (count != '0);
  assign head.head      = mem[rd_ptr];

  // Storage for queued items.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: hdl/zlj_back.sv
module zlj_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  input  logic                cfg_data,
  input  zlj_pkg::fifo_head_t head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                char_valid,
  output logic [7:0]          out_char,
  output logic                line_done,
  output logic [1:0]          line_status,
  output logic [16:0]         line_length
);
  import zlj_pkg::*;

  logic               hold_comments;
  logic               quoting;
  logic [DEPTH_W-1:0] paren_depth;
  logic               skipping_comment;
  logic               prev_bslash;
  logic [CNT_W-1:0]   steps_taken;
  logic [CNT_W-1:0]   chars_emitted;

  logic               quoting_next;
  logic [DEPTH_W-1:0] paren_depth_next;
  logic               skipping_next;
  logic [CNT_W-1:0]   chars_next;
  logic [CNT_W-1:0]   steps_next;

  logic               escaped;
  logic               emit;
  logic               closed_early;
  logic               done;
  logic               result;
  logic [7:0]         ch;
  status_t            status;
  logic               out_free;

  // The output register frees up when it is empty or being taken.
  assign out_free = !out_valid || !out_stall;
  assign pop      = head.not_empty && out_free;
  assign escaped  = prev_bslash;

  // Per-byte state update.
  always_comb begin
    quoting_next     = quoting;
    paren_depth_next = paren_depth;
    skipping_next    = skipping_comment;
    emit             = 1'b0;
    closed_early     = 1'b0;
    done             = 1'b0;
    ch               = head.head.data;
    status           = STAT_OK;
    chars_next       = chars_emitted;
    steps_next       = steps_taken;

    if (head.head.cls == CLS_EOF) begin
      closed_early = 1'b1;
      if (chars_emitted == '0) begin
        status = STAT_NO_LINE;
      end else if (paren_depth != '0) begin
        status = STAT_MISSING_CLOSE;
      end
    end else if (!(skipping_comment && head.head.cls != CLS_NL)) begin
      case (head.head.cls)
        CLS_QUOTE: begin
          emit = 1'b1;
          if (!escaped) begin
            quoting_next = !quoting;
          end
        end
        CLS_OPEN: begin
          emit = 1'b1;
          if (!quoting && !escaped) begin
            ch = CH_SPACE;
            if (paren_depth != DEPTH_W'(MAX_DEPTH)) begin
              paren_depth_next = paren_depth + 1'b1;
            end
          end
        end
        CLS_CLOSE: begin
          if (quoting || escaped) begin
            emit = 1'b1;
          end else if (paren_depth == '0) begin
            closed_early = 1'b1;
            status       = STAT_MISSING_OPEN;
          end else begin
            emit             = 1'b1;
            ch               = CH_SPACE;
            paren_depth_next = paren_depth - 1'b1;
          end
        end
        CLS_SEMI: begin
          if (!quoting && !escaped && !hold_comments) begin
            skipping_next = 1'b1;
          end else begin
            emit = 1'b1;
          end
        end
        CLS_NL: begin
          if (escaped) begin
            emit = 1'b1;
          end else begin
            skipping_next = 1'b0;
            if (paren_depth == '0) begin
              closed_early = 1'b1;
            end else begin
              emit = 1'b1;
              ch   = CH_SPACE;
            end
          end
        end
        default: begin
          emit = 1'b1;
        end
      endcase

      if (!closed_early) begin
        steps_next = steps_taken + 1'b1;
        if (emit) begin
          chars_next = chars_emitted + 1'b1;
        end
        if (steps_taken == CNT_W'(MAX_LINE - 1)) begin
          done = 1'b1;
          if (paren_depth_next != '0) begin
            status = STAT_MISSING_CLOSE;
          end
        end
      end
    end

    result = emit || done || closed_early;
  end

  // Configuration register; always ready.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_comments <= 1'b0;
    end else if (cfg_valid) begin
      hold_comments <= cfg_data;
    end
  end

  // Line state, cleared when a line closes.
  always_ff @(posedge clk) begin
    if (rst) begin
      quoting          <= 1'b0;
      paren_depth      <= '0;
      skipping_comment <= 1'b0;
      prev_bslash      <= 1'b0;
      steps_taken      <= '0;
      chars_emitted    <= '0;
    end else if (pop) begin
      if (done || closed_early) begin
        quoting          <= 1'b0;
        paren_depth      <= '0;
        skipping_comment <= 1'b0;
        prev_bslash      <= 1'b0;
        steps_taken      <= '0;
        chars_emitted    <= '0;
      end else if (!(skipping_comment && head.head.cls != CLS_NL)) begin
        quoting          <= quoting_next;
        paren_depth      <= paren_depth_next;
        skipping_comment <= skipping_next;
        prev_bslash      <= (head.head.cls == CLS_BSLASH);
        steps_taken      <= steps_next;
        chars_emitted    <= chars_next;
      end
    end
  end

  // Output register valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= pop && result;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (pop && result) begin
      char_valid  <= emit;
      out_char    <= emit ? ch : 8'h00;
      line_done   <= done || closed_early;
      line_status <= status;
      line_length <= chars_next[LEN_W-1:0];
    end
  end

endmodule
